>>> rtl/lgs_pkg.sv
package lgs_pkg;

  // command codes of an input transaction
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;

  // life rule: birth on three neighbors, survival on two (or three)
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // fixed widths of the transaction fields
  localparam int unsigned CmdW   = 2;
  localparam int unsigned CoordW = 5;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic cell_op;   // read data of a single cell access is back
    logic adv_step;  // one step of the generation sweep
    logic load_out;  // move the result into the output register
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_cell_ok;  // pending input is a read or write inside the grid
    logic in_advance;  // pending input is an advance
    logic adv_last;    // last step of the sweep
    logic out_free;    // output register can take a result
  } status_t;

endpackage

>>> rtl/lgs_ram.sv
module lgs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/lgs_ctrl.sv
module lgs_ctrl
  import lgs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CELL = 2'd1;
  localparam logic [1:0] S_ADV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.accept = 1'b1;
          if (status_i.in_cell_ok) begin
            state_d = S_CELL;
          end else if (status_i.in_advance) begin
            state_d = S_ADV;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_CELL: begin
        ctrl_o.cell_op = 1'b1;
        state_d        = S_DONE;
      end
      S_ADV: begin
        ctrl_o.adv_step = 1'b1;
        if (status_i.adv_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          ctrl_o.load_out = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/lgs_datapath.sv
module lgs_datapath
  import lgs_pkg::*;
#(
  parameter int unsigned GRID_SIZE = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CmdW-1:0]   cmd_i,
  input  logic [CoordW-1:0] row_i,
  input  logic [CoordW-1:0] col_i,
  input  logic              cell_value_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              cell_alive_o,
  input  ctrl_t             ctrl_i,
  output status_t           status_o
);

  localparam int unsigned AW   = $clog2(GRID_SIZE);
  localparam int unsigned CNTW = $clog2(GRID_SIZE + 2);
  localparam int unsigned CW   = 7;

  // per-row valid bits, a row not yet written reads as all dead
  logic [GRID_SIZE-1:0] row_vld_q;

  logic [AW-1:0]        row_idx_q, col_idx_q;
  logic                 is_write_q, val_q;
  logic                 res_q;
  logic                 out_valid_q, cell_alive_q;
  logic                 rvld_q;
  logic [CNTW-1:0]      cnt_q;
  logic [GRID_SIZE-1:0] above_q, center_q;

  logic                 in_inside;
  logic [AW-1:0]        in_row_idx;
  logic [AW-1:0]        sweep_raddr, sweep_waddr;
  logic                 sweep_rd;
  logic [AW-1:0]        raddr;
  logic                 ram_we;
  logic [AW-1:0]        waddr;
  logic [GRID_SIZE-1:0] wdata, rdata, row_data, cell_wdata, new_row;
  logic                 rvld_d;

  assign in_inside = ({2'b00, row_i} < CW'(GRID_SIZE)) && ({2'b00, col_i} < CW'(GRID_SIZE));
  assign in_row_idx = in_inside ? AW'(row_i) : '0;

  assign status_o.in_cell_ok = in_inside && ((cmd_i == CMD_WRITE) || (cmd_i == CMD_READ));
  assign status_o.in_advance = (cmd_i == CMD_ADVANCE);
  assign status_o.adv_last   = (cnt_q == CNTW'(GRID_SIZE + 1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // sweep: read row cnt, write row cnt-2 once its lower neighbor is in
  assign sweep_rd    = (cnt_q < CNTW'(GRID_SIZE));
  assign sweep_raddr = sweep_rd ? AW'(cnt_q) : '0;
  assign sweep_waddr = AW'(CNTW'(cnt_q - CNTW'(2)));

  assign raddr = ctrl_i.adv_step ? sweep_raddr : in_row_idx;

  always_comb begin
    rvld_d = 1'b0;
    if (ctrl_i.accept) begin
      rvld_d = status_o.in_cell_ok && row_vld_q[in_row_idx];
    end else if (ctrl_i.adv_step) begin
      rvld_d = sweep_rd && row_vld_q[sweep_raddr];
    end
  end

  assign row_data = rvld_q ? rdata : '0;

  always_comb begin
    cell_wdata            = row_data;
    cell_wdata[col_idx_q] = val_q;
  end

  // next generation of the center row from the three-row window
  logic [GRID_SIZE+1:0] up_x, mid_x, dn_x;
  assign up_x  = {1'b0, above_q, 1'b0};
  assign mid_x = {1'b0, center_q, 1'b0};
  assign dn_x  = {1'b0, row_data, 1'b0};

  for (genvar c = 0; c < GRID_SIZE; c++) begin : g_col
    logic [3:0] nbr;
    assign nbr = {3'b000, up_x[c]} + {3'b000, up_x[c+1]} + {3'b000, up_x[c+2]}
               + {3'b000, mid_x[c]} + {3'b000, mid_x[c+2]}
               + {3'b000, dn_x[c]} + {3'b000, dn_x[c+1]} + {3'b000, dn_x[c+2]};
    assign new_row[c] = (nbr == BIRTH_COUNT) || ((nbr == SURVIVE_COUNT) && mid_x[c+1]);
  end

  assign ram_we = (ctrl_i.cell_op && is_write_q)
               || (ctrl_i.adv_step && (cnt_q >= CNTW'(2)));
  assign waddr  = ctrl_i.adv_step ? sweep_waddr : row_idx_q;
  assign wdata  = ctrl_i.adv_step ? new_row : cell_wdata;

  lgs_ram #(
    .WIDTH(GRID_SIZE),
    .DEPTH(GRID_SIZE)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // transaction fields and result
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      row_idx_q  <= in_row_idx;
      col_idx_q  <= in_inside ? AW'(col_i) : '0;
      is_write_q <= (cmd_i == CMD_WRITE);
      val_q      <= cell_value_i;
      res_q      <= 1'b0;
    end else if (ctrl_i.cell_op) begin
      res_q <= is_write_q ? val_q : row_data[col_idx_q];
    end
    if (ctrl_i.accept) begin
      above_q  <= '0;
      center_q <= '0;
    end else if (ctrl_i.adv_step) begin
      above_q  <= center_q;
      center_q <= row_data;
    end
    if (ctrl_i.load_out) begin
      cell_alive_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q   <= '0;
      rvld_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rvld_q <= rvld_d;
      if (ram_we) begin
        row_vld_q[waddr] <= 1'b1;
      end
      if (ctrl_i.accept) begin
        cnt_q <= '0;
      end else if (ctrl_i.adv_step) begin
        cnt_q <= CNTW'(cnt_q + CNTW'(1));
      end
      if (ctrl_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_alive_o = cell_alive_q;

endmodule

>>> rtl/life_grid_generation_step.sv
// flow: a read or write is accepted in idle, then passes the cell access state and the done state;
// an advance runs the generation sweep state and then the done state; an unused cmd or an address
// off the grid goes straight to the done state; a new transaction is taken only in idle, set by
// the one-row-per-cycle sweep over the grid ram (advance) and the ram read-modify-write (read,
// write); a result waiting in the output register does not block acceptance of the next transaction
// reset: asynchronous active low, all cells read dead after reset through per-row valid bits
module life_grid_generation_step
  import lgs_pkg::*;
#(
  parameter int unsigned GRID_SIZE = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input transaction
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CmdW-1:0]   cmd_i,
  input  logic [CoordW-1:0] row_i,
  input  logic [CoordW-1:0] col_i,
  input  logic              cell_value_i,
  // result transaction
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              cell_alive_o
);

  ctrl_t   ctrl;
  status_t status;

  // controller: idle, single cell access, generation sweep, result handoff
  lgs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .ctrl_o    (ctrl)
  );

  // datapath: grid ram, three-row window for the rule, output register
  lgs_datapath #(
    .GRID_SIZE(GRID_SIZE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .cell_value_i(cell_value_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cell_alive_o(cell_alive_o),
    .ctrl_i      (ctrl),
    .status_o    (status)
  );

endmodule

>>> dv/tb_life_grid_generation_step.sv
module tb_life_grid_generation_step;
  import lgs_pkg::*;

  localparam int GRID_SIZE = 32;
  // cmd code the block leaves unused: no change, result dead
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 900;
  // worst case: every transaction an advance behind long gaps and stalls
  localparam int CYCLE_LIMIT = 400000;
  // long receiver hold-off, placed after this many results
  localparam int HOLD_AT = 150;
  localparam int HOLD_LEN = 400;

  typedef struct {
    logic [1:0] cmd;
    logic [4:0] row;
    logic [4:0] col;
    logic       val;
  } life_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [CmdW-1:0] cmd_i = '0;
  logic [CoordW-1:0] row_i = '0;
  logic [CoordW-1:0] col_i = '0;
  logic cell_value_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic cell_alive_o;

  life_grid_generation_step #(
    .GRID_SIZE(GRID_SIZE)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .cell_value_i(cell_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cell_alive_o(cell_alive_o)
  );

  // commands waiting to be driven, and cell values still owed by the block
  life_cmd_t stim_q[$];
  logic alive_expect_q[$];
  int fail_count = 0;
  int cycle_count = 0;

  // shadow copy of the grid, one row per word, bit index is the column
  logic [GRID_SIZE-1:0] life_grid[GRID_SIZE];

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // reset held low at the start of the run only
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // cells off the grid count as dead, no wraparound
  function automatic logic cell_at(int r, int c);
    if (r < 0 || c < 0 || r >= GRID_SIZE || c >= GRID_SIZE) return 1'b0;
    return life_grid[r][c];
  endfunction

  // one synchronous generation, B3/S23
  task automatic advance_generation();
    logic [GRID_SIZE-1:0] next_grid[GRID_SIZE];
    int n;
    for (int r = 0; r < GRID_SIZE; r++) begin
      for (int c = 0; c < GRID_SIZE; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0) n += cell_at(r + dr, c + dc);
        if (n == BIRTH_COUNT) next_grid[r][c] = 1'b1;
        else if (n == SURVIVE_COUNT) next_grid[r][c] = life_grid[r][c];
        else next_grid[r][c] = 1'b0;
      end
    end
    for (int r = 0; r < GRID_SIZE; r++) life_grid[r] = next_grid[r];
  endtask

  // apply one accepted transaction to the shadow grid, return the cell value it yields
  task automatic apply_life_cmd(input life_cmd_t t, output logic alive);
    logic on_grid;
    on_grid = (t.row < GRID_SIZE) && (t.col < GRID_SIZE);
    alive = 1'b0;
    case (t.cmd)
      CMD_WRITE: begin
        if (on_grid) begin
          life_grid[t.row][t.col] = t.val;
          alive = t.val;
        end
      end
      CMD_READ: begin
        if (on_grid) alive = life_grid[t.row][t.col];
      end
      CMD_ADVANCE: begin
        advance_generation();
      end
      default: ;
    endcase
  endtask

  task automatic queue_cmd(input logic [1:0] cmd, input logic [4:0] row, input logic [4:0] col,
                           input logic val);
    life_cmd_t t;
    t.cmd = cmd;
    t.row = row;
    t.col = col;
    t.val = val;
    stim_q.push_back(t);
  endtask

  // mostly short gaps, a few long ones, plenty of back-to-back stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: predicts on acceptance, then offers the next pending transaction
  int send_gap = 0;
  always @(posedge clk_i) begin
    life_cmd_t cur;
    life_cmd_t nxt;
    logic alive;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        cur.cmd = cmd_i;
        cur.row = row_i;
        cur.col = col_i;
        cur.val = cell_value_i;
        apply_life_cmd(cur, alive);
        alive_expect_q.push_back(alive);
      end
      // bus is free once the offered transaction is taken or nothing was offered
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (stim_q.size() > 0) begin
          nxt = stim_q.pop_front();
          cmd_i <= nxt.cmd;
          row_i <= nxt.row;
          col_i <= nxt.col;
          cell_value_i <= nxt.val;
          in_valid_i <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result against the oldest owed value, drives ready
  int hold_left = 0;
  int results_seen = 0;
  logic long_hold_done = 1'b0;
  always @(posedge clk_i) begin
    logic want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (alive_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual cell_alive %0b",
                   $time, cell_alive_o);
          fail_count++;
        end else begin
          want = alive_expect_q.pop_front();
          if (cell_alive_o !== want) begin
            $display("%0t: cell_alive mismatch, expected %0b actual %0b",
                     $time, want, cell_alive_o);
            fail_count++;
          end
        end
      end
      // one long hold-off lets the block fill up and stall its input side
      if (!long_hold_done && results_seen >= HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 99) < 10) begin
        hold_left = pick_gap();
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("life_grid_generation_step verification failed");
      $finish;
    end
  end

  initial begin
    logic [4:0] r0;
    logic [4:0] c0;
    int span;
    int kind;
    int n_directed;
    int n_total;
    for (int r = 0; r < GRID_SIZE; r++) life_grid[r] = '0;

    // corners of the grid
    queue_cmd(CMD_WRITE, 5'd0, 5'd0, 1'b1);
    queue_cmd(CMD_WRITE, 5'd0, 5'd31, 1'b1);
    queue_cmd(CMD_WRITE, 5'd31, 5'd0, 1'b1);
    queue_cmd(CMD_WRITE, 5'd31, 5'd31, 1'b1);
    queue_cmd(CMD_READ, 5'd31, 5'd31, 1'b0);
    queue_cmd(CMD_WRITE, 5'd31, 5'd31, 1'b0);
    queue_cmd(CMD_READ, 5'd31, 5'd31, 1'b1);
    // unused cmd code with every other field set
    queue_cmd(CMD_UNUSED, 5'd31, 5'd31, 1'b1);
    queue_cmd(CMD_READ, 5'd0, 5'd0, 1'b1);
    // blinker on the top edge, nothing wraps to the bottom row
    queue_cmd(CMD_WRITE, 5'd0, 5'd14, 1'b1);
    queue_cmd(CMD_WRITE, 5'd0, 5'd15, 1'b1);
    queue_cmd(CMD_WRITE, 5'd0, 5'd16, 1'b1);
    // still block in the bottom right corner
    queue_cmd(CMD_WRITE, 5'd30, 5'd30, 1'b1);
    queue_cmd(CMD_WRITE, 5'd30, 5'd31, 1'b1);
    queue_cmd(CMD_WRITE, 5'd31, 5'd30, 1'b1);
    queue_cmd(CMD_WRITE, 5'd31, 5'd31, 1'b1);
    // advance ignores its address and value fields
    queue_cmd(CMD_ADVANCE, 5'd31, 5'd31, 1'b1);
    queue_cmd(CMD_READ, 5'd1, 5'd15, 1'b0);
    queue_cmd(CMD_READ, 5'd0, 5'd14, 1'b0);
    queue_cmd(CMD_READ, 5'd31, 5'd15, 1'b0);
    queue_cmd(CMD_ADVANCE, 5'd0, 5'd0, 1'b0);
    queue_cmd(CMD_READ, 5'd0, 5'd14, 1'b0);
    queue_cmd(CMD_READ, 5'd31, 5'd31, 1'b0);
    queue_cmd(CMD_READ, 5'd0, 5'd0, 1'b0);
    n_directed = stim_q.size();

    // random part: mostly small patterns seeded, evolved a few steps and probed
    while (stim_q.size() < n_directed + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        r0 = 5'($urandom);
        c0 = 5'($urandom);
        span = $urandom_range(2, 4);
        repeat ($urandom_range(3, 8))
          queue_cmd(CMD_WRITE, r0 + 5'($urandom_range(0, span - 1)),
                    c0 + 5'($urandom_range(0, span - 1)), $urandom_range(0, 3) != 0);
        repeat ($urandom_range(1, 3))
          queue_cmd(CMD_ADVANCE, 5'($urandom), 5'($urandom), 1'($urandom));
        repeat ($urandom_range(2, 6))
          queue_cmd(CMD_READ, r0 - 5'd1 + 5'($urandom_range(0, span + 1)),
                    c0 - 5'd1 + 5'($urandom_range(0, span + 1)), 1'($urandom));
      end else if (kind < 85) begin
        // wipe a row segment so the grid does not saturate
        r0 = 5'($urandom);
        c0 = 5'($urandom);
        repeat ($urandom_range(2, 6)) begin
          queue_cmd(CMD_WRITE, r0, c0, 1'b0);
          c0 = c0 + 5'd1;
        end
      end else begin
        // noise: any field value, unused cmd included
        queue_cmd(2'($urandom), 5'($urandom), 5'($urandom), 1'($urandom));
      end
    end
    n_total = stim_q.size();

    @(posedge rst_ni);
    // every transaction returns exactly one result
    while (results_seen < n_total) @(posedge clk_i);
    // leave room for a stray extra result before judging
    repeat (GRID_SIZE + 12) @(posedge clk_i);
    if (fail_count == 0 && alive_expect_q.size() == 0) begin
      $display("life_grid_generation_step verification clean");
    end else begin
      $display("life_grid_generation_step verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/lgs_pkg.sv
rtl/lgs_ram.sv
rtl/lgs_ctrl.sv
rtl/lgs_datapath.sv
rtl/life_grid_generation_step.sv
dv/tb_life_grid_generation_step.sv
